@@ rtl/dwrc_pkg.sv @@
// Shared types and constants for the deque with read cursor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dwrc_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;

    typedef enum logic [1:0] {
        ACT_APPEND     = 2'd0,
        ACT_PREPEND    = 2'd1,
        ACT_READ_FIRST = 2'd2,
        ACT_READ_NEXT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOCUR = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } t_cmd;

endpackage

@@ rtl/dwrc_ctrl.sv @@
// Sequencer for the deque: accept, execute, result load.
// Depends on dwrc_pkg.
`timescale 1ns / 1ps

module dwrc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dwrc_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_out_valid;

    assign o_cmd.capture = i_in_valid && r_ready;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (o_cmd.load) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready  = r_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/dwrc_datapath.sv @@
// Ring store, end pointers, cursor and result register of the deque.
// Depends on dwrc_pkg; sequenced by dwrc_ctrl.
`timescale 1ns / 1ps

module dwrc_datapath #(
    parameter int DEPTH      = dwrc_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = dwrc_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dwrc_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                     i_action,
    input  logic [dwrc_pkg::VALUE_W-1:0]   i_item_value,
    output logic [1:0]                     o_status,
    output logic [dwrc_pkg::VALUE_W-1:0]   o_read_value
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (ELEM_WIDTH < dwrc_pkg::VALUE_W) ? ELEM_WIDTH : dwrc_pkg::VALUE_W;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [SW-1:0] r_mem [DEPTH];
    logic [SW-1:0] r_rd;

    dwrc_pkg::t_action r_act;
    logic [SW-1:0]     r_val;

    logic [PW-1:0] r_front, n_front;
    logic [PW-1:0] r_back, n_back;
    logic [PW-1:0] r_cursor, n_cursor;
    logic          r_cvalid, n_cvalid;
    logic [CW-1:0] r_count, n_count;

    dwrc_pkg::t_status r_status, n_status;
    logic              r_hit, n_hit;

    dwrc_pkg::t_status            r_out_status;
    logic [dwrc_pkg::VALUE_W-1:0] r_out_value;

    logic          we;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] rd_addr;
    logic          full;
    logic          empty;
    logic [PW-1:0] back_inc;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] cursor_inc;

    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign back_inc   = (r_back == LAST) ? '0 : r_back + PW'(1);
    assign front_dec  = (r_front == '0) ? LAST : r_front - PW'(1);
    assign cursor_inc = (r_cursor == LAST) ? '0 : r_cursor + PW'(1);

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_cursor = r_cursor;
        n_cvalid = r_cvalid;
        n_count  = r_count;
        n_status = dwrc_pkg::ST_OK;
        n_hit    = 1'b0;
        we       = 1'b0;
        wr_addr  = r_front;
        rd_addr  = r_front;
        unique case (r_act) inside
            dwrc_pkg::ACT_APPEND, dwrc_pkg::ACT_PREPEND: begin
                if (full) begin
                    n_status = dwrc_pkg::ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    if (empty) begin
                        n_back  = r_front;
                        wr_addr = r_front;
                    end else if (r_act == dwrc_pkg::ACT_APPEND) begin
                        n_back  = back_inc;
                        wr_addr = back_inc;
                    end else begin
                        n_front = front_dec;
                        wr_addr = front_dec;
                    end
                end
            end
            dwrc_pkg::ACT_READ_FIRST: begin
                if (empty) begin
                    n_status = dwrc_pkg::ST_END;
                end else begin
                    n_cursor = r_front;
                    n_cvalid = 1'b1;
                    n_hit    = 1'b1;
                    rd_addr  = r_front;
                end
            end
            dwrc_pkg::ACT_READ_NEXT: begin
                if (!r_cvalid) begin
                    n_status = dwrc_pkg::ST_NOCUR;
                end else if (r_cursor == r_back) begin
                    n_status = dwrc_pkg::ST_END;
                end else begin
                    n_cursor = cursor_inc;
                    n_hit    = 1'b1;
                    rd_addr  = cursor_inc;
                end
            end
            default: begin
                n_status = dwrc_pkg::ST_OK;
            end
        endcase
    end

    // ring store, registered read taken in the execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && we) begin
            r_mem[wr_addr] <= r_val;
        end
        if (i_cmd.execute) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= dwrc_pkg::t_action'(i_action);
            r_val <= i_item_value[SW-1:0];
        end
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_hit    <= n_hit;
        end
        if (i_cmd.load) begin
            r_out_status <= r_status;
            r_out_value  <= r_hit ? dwrc_pkg::VALUE_W'(r_rd) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= '0;
            r_cursor <= '0;
            r_cvalid <= 1'b0;
            r_count  <= '0;
        end else if (i_cmd.execute) begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_cursor <= n_cursor;
            r_cvalid <= n_cvalid;
            r_count  <= n_count;
        end
    end

    assign o_status     = r_out_status;
    assign o_read_value = r_out_value;

endmodule

@@ rtl/deque_with_read_cursor_unit.sv @@
// Top level of the deque with read cursor: controller plus datapath.
// Depends on dwrc_pkg, dwrc_ctrl and dwrc_datapath.
//
// Channel  Dir  tdata               tuser
// s_axis   in   [31:0] item_value   [1:0] action
// m_axis   out  [31:0] read_value   [1:0] status
//
// Each request passes through capture, execute (pointer update and
// ring store access) and result load; the store read is registered.
// The result register frees the input side once loaded; a held result
// stalls only the load of the next one.
// Synchronous active-low reset clears pointers, count and cursor; the
// store itself is not cleared.
`timescale 1ns / 1ps

module deque_with_read_cursor_unit #(
    parameter int DEPTH      = dwrc_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = dwrc_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dwrc_pkg::VALUE_W-1:0] s_axis_tdata,  // [31:0] item_value
    input  logic [1:0]                   s_axis_tuser,  // [1:0] action
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dwrc_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] read_value
    output logic [1:0]                   m_axis_tuser   // [1:0] status
);

    dwrc_pkg::t_cmd cmd;

    dwrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    dwrc_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (s_axis_tuser),
        .i_item_value (s_axis_tdata),
        .o_status     (m_axis_tuser),
        .o_read_value (m_axis_tdata)
    );

endmodule

@@ rtl/dwrc_checker.sv @@
// Port-level checks for deque_with_read_cursor_unit, bound to the top level.
// Depends on dwrc_pkg.
`timescale 1ns / 1ps

module dwrc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [dwrc_pkg::VALUE_W-1:0] m_axis_tdata,
    input logic [1:0]                   m_axis_tuser
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // failed requests return no value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != dwrc_pkg::ST_OK) |-> m_axis_tdata == '0)
        else $error("non-zero value on failed transaction");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind deque_with_read_cursor_unit dwrc_checker u_dwrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/dwrc_reply_checker.sv @@
// Reply checker for the deque with read cursor: mirrors the ring store, end pointers
// and cursor, and compares each m_axis transaction with the oldest reply due.
// Depends on dwrc_pkg.
`timescale 1ns / 1ps

module dwrc_reply_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [dwrc_pkg::VALUE_W-1:0] i_s_tdata,  // [31:0] item_value
    input  logic [1:0]                   i_s_tuser,  // [1:0] action
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [dwrc_pkg::VALUE_W-1:0] i_m_tdata,  // [31:0] read_value
    input  logic [1:0]                   i_m_tuser,  // [1:0] status
    output int                           o_error_count,
    output int                           o_outstanding
);

    localparam int DEPTH  = dwrc_pkg::DEPTH_DEF;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int VW     = dwrc_pkg::VALUE_W;
    localparam logic [VW-1:0] ELEM_MASK = {VW{1'b1}} >> (VW - dwrc_pkg::ELEM_WIDTH_DEF);

    typedef struct packed {
        dwrc_pkg::t_status status;
        logic [VW-1:0]     value;
    } t_reply;

    logic [VW-1:0]     ring [DEPTH];
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] walk_slot;
    int                stored;
    logic              walk_valid;
    t_reply            replies_due [$];
    int                mismatch_total = 0;

    function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // Applies one request to the mirrored list and returns the reply it yields.
    function automatic t_reply deque_access(dwrc_pkg::t_action act, logic [VW-1:0] item);
        t_reply r;
        r.status = dwrc_pkg::ST_OK;
        r.value  = '0;
        case (act) inside
            dwrc_pkg::ACT_APPEND, dwrc_pkg::ACT_PREPEND: begin
                if (stored >= DEPTH) begin
                    r.status = dwrc_pkg::ST_FULL;
                end else begin
                    // first entry sits at the front slot and is both ends
                    if (stored == 0) begin
                        tail_slot = head_slot;
                    end else if (act == dwrc_pkg::ACT_APPEND) begin
                        tail_slot = next_slot(tail_slot);
                    end else begin
                        head_slot = (head_slot == '0) ? SLOT_W'(DEPTH - 1) : head_slot - 1'b1;
                    end
                    if (act == dwrc_pkg::ACT_APPEND) begin
                        ring[tail_slot] = item & ELEM_MASK;
                    end else begin
                        ring[head_slot] = item & ELEM_MASK;
                    end
                    stored++;
                end
            end
            dwrc_pkg::ACT_READ_FIRST: begin
                if (stored == 0) begin
                    r.status = dwrc_pkg::ST_END;
                end else begin
                    walk_slot  = head_slot;
                    walk_valid = 1'b1;
                    r.value    = ring[walk_slot];
                end
            end
            default: begin
                if (!walk_valid) begin
                    r.status = dwrc_pkg::ST_NOCUR;
                end else if (walk_slot == tail_slot) begin
                    r.status = dwrc_pkg::ST_END;
                end else begin
                    walk_slot = next_slot(walk_slot);
                    r.value   = ring[walk_slot];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply due;
        if (!i_rst_n) begin
            head_slot  = '0;
            tail_slot  = '0;
            walk_slot  = '0;
            stored     = 0;
            walk_valid = 1'b0;
            replies_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(deque_access(dwrc_pkg::t_action'(i_s_tuser), i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected transaction, status %0d read_value %h",
                             $time, i_m_tuser, i_m_tdata);
                    mismatch_total++;
                end else begin
                    due = replies_due.pop_front();
                    if (i_m_tuser !== due.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, due.status, i_m_tuser);
                        mismatch_total++;
                    end
                    if (i_m_tdata !== due.value) begin
                        $display("%0t: read_value expected %h, actual %h",
                                 $time, due.value, i_m_tdata);
                        mismatch_total++;
                    end
                end
            end
        end
        o_error_count <= mismatch_total;
        o_outstanding <= replies_due.size();
    end

endmodule

@@ tb/sv/deque_with_read_cursor_unit_tb.sv @@
// Testbench top for deque_with_read_cursor_unit: drives bursty requests and a
// stalling sink, and gives the verdict from dwrc_reply_checker.
// Depends on dwrc_pkg, deque_with_read_cursor_unit and dwrc_reply_checker.
`timescale 1ns / 1ps

module deque_with_read_cursor_unit_tb;

    localparam int ITEMS        = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [dwrc_pkg::VALUE_W-1:0] s_axis_tdata  = '0;  // [31:0] item_value
    logic [1:0]                   s_axis_tuser  = dwrc_pkg::ACT_APPEND;  // [1:0] action
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [dwrc_pkg::VALUE_W-1:0] m_axis_tdata;  // [31:0] read_value
    logic [1:0]                   m_axis_tuser;  // [1:0] status

    int         error_count;
    int         outstanding;
    int         burst_left  = 0;
    int         sent        = 0;
    int         idle_cycles = 0;
    logic [8:0] sink_cycle  = '0;

    deque_with_read_cursor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dwrc_reply_checker reply_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // sink: free-running pattern of ready phases
    always @(posedge i_clk) begin
        case (sink_cycle[8:7])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 0);
            2'd2:    m_axis_tready <= (sink_cycle[3:0] < 4'd5);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
        sink_cycle <= sink_cycle + 1'b1;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("deque_with_read_cursor_unit_tb: errors");
            $finish;
        end
    end

    task automatic send_request(dwrc_pkg::t_action act, logic [dwrc_pkg::VALUE_W-1:0] item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        sent++;
    endtask

    initial begin
        int walk_len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(dwrc_pkg::ACT_READ_NEXT, 32'hFFFF_FFFF);   // no cursor yet
        send_request(dwrc_pkg::ACT_READ_FIRST, 32'h0);          // empty list
        send_request(dwrc_pkg::ACT_PREPEND, 32'h0);             // prepend into empty list
        send_request(dwrc_pkg::ACT_READ_NEXT, 32'h0);           // still no cursor
        send_request(dwrc_pkg::ACT_READ_FIRST, 32'hFFFF_FFFF);
        send_request(dwrc_pkg::ACT_READ_NEXT, 32'h0);           // cursor on back entry
        send_request(dwrc_pkg::ACT_APPEND, 32'hFFFF_FFFF);
        send_request(dwrc_pkg::ACT_READ_NEXT, 32'h0);
        send_request(dwrc_pkg::ACT_READ_NEXT, 32'h0);
        send_request(dwrc_pkg::ACT_PREPEND, 32'h8000_0001);     // front wraps round the ring
        send_request(dwrc_pkg::ACT_READ_NEXT, 32'h0);
        send_request(dwrc_pkg::ACT_READ_FIRST, 32'h0);
        repeat (dwrc_pkg::DEPTH_DEF - 3) begin
            send_request(($urandom_range(0, 1) == 0) ? dwrc_pkg::ACT_APPEND
                                                     : dwrc_pkg::ACT_PREPEND, $urandom());
        end
        send_request(dwrc_pkg::ACT_APPEND, 32'h5A5A_A5A5);      // store full
        send_request(dwrc_pkg::ACT_PREPEND, 32'hA5A5_5A5A);

        while (sent < ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                send_request(dwrc_pkg::ACT_READ_FIRST, $urandom());
                walk_len = $urandom_range(1, dwrc_pkg::DEPTH_DEF + 2);
                repeat (walk_len) send_request(dwrc_pkg::ACT_READ_NEXT, $urandom());
            end else begin
                send_request(dwrc_pkg::t_action'($urandom_range(0, 3)),
                             ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom());
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("deque_with_read_cursor_unit_tb: clean");
        end else begin
            $display("deque_with_read_cursor_unit_tb: errors");
        end
        $finish;
    end

endmodule
